// File: sv/dtiu_pkg.sv
// ----------------------------------------------------------------------------
// dtiu_pkg - shared types and constants of the decimal text converter
// Character codes, token format and unit shift amounts.
// ----------------------------------------------------------------------------
package dtiu_pkg;

  localparam int unsigned SHIFT_W     = 6;
  localparam int unsigned QUEUE_DEPTH = 4;

  // Binary unit shifts
  localparam logic [SHIFT_W-1:0] SHIFT_NONE = 6'd0;
  localparam logic [SHIFT_W-1:0] SHIFT_K    = 6'd10;
  localparam logic [SHIFT_W-1:0] SHIFT_M    = 6'd20;
  localparam logic [SHIFT_W-1:0] SHIFT_G    = 6'd30;
  localparam logic [SHIFT_W-1:0] SHIFT_T    = 6'd40;

  // Character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UC_G  = 8'h47;
  localparam logic [7:0] CH_UC_K  = 8'h4B;
  localparam logic [7:0] CH_UC_M  = 8'h4D;
  localparam logic [7:0] CH_UC_T  = 8'h54;
  localparam logic [7:0] CH_LC_G  = 8'h67;
  localparam logic [7:0] CH_LC_K  = 8'h6B;
  localparam logic [7:0] CH_LC_M  = 8'h6D;
  localparam logic [7:0] CH_LC_T  = 8'h74;

  typedef enum logic [2:0] {
    TK_DIGIT,
    TK_POINT,
    TK_BLANK,
    TK_NUL,
    TK_OTHER
  } tok_kind_e;

  // One classified character
  typedef struct packed {
    tok_kind_e          kind;
    logic [3:0]         digit;
    logic [SHIFT_W-1:0] shift;  // unit shift, zero for a non-unit byte
    logic               last;
  } token_t;

endpackage

// File: sv/dtiu_if.sv
// ----------------------------------------------------------------------------
// dtiu_if - request channels of the decimal text converter
// Character input channel and result output channel, valid/ready.
// ----------------------------------------------------------------------------
interface dtiu_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       last;

  modport source (output valid, output char_in, output last, input ready);
  modport sink   (input valid, input char_in, input last, output ready);
endinterface

interface dtiu_res_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] value;
  logic signed [31:0] value_int;

  modport source (output valid, output value, output value_int, input ready);
  modport sink   (input valid, input value, input value_int, output ready);
endinterface

// File: sv/dtiu_front.sv
// ----------------------------------------------------------------------------
// dtiu_front - character classifier
// Accepts text bytes and registers them as classified tokens.
// ----------------------------------------------------------------------------
module dtiu_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  dtiu_char_if.sink       in_i,
  output logic            tok_valid_o,
  input  logic            tok_ready_i,
  output dtiu_pkg::token_t tok_o
);
  import dtiu_pkg::*;

  logic   tok_valid_q;
  token_t tok_q, tok_d;
  logic   accept;

  assign in_i.ready = !tok_valid_q || tok_ready_i;
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    tok_d.kind  = TK_OTHER;
    tok_d.digit = in_i.char_in[3:0];
    tok_d.shift = SHIFT_NONE;
    tok_d.last  = in_i.last;
    case (in_i.char_in) inside
      [CH_0:CH_9]:        tok_d.kind = TK_DIGIT;
      CH_DOT, CH_COMMA:   tok_d.kind = TK_POINT;
      CH_SPACE, CH_TAB:   tok_d.kind = TK_BLANK;
      CH_NUL:             tok_d.kind = TK_NUL;
      CH_UC_K, CH_LC_K:   tok_d.shift = SHIFT_K;
      CH_UC_M, CH_LC_M:   tok_d.shift = SHIFT_M;
      CH_UC_G, CH_LC_G:   tok_d.shift = SHIFT_G;
      CH_UC_T, CH_LC_T:   tok_d.shift = SHIFT_T;
      default:            tok_d.kind = TK_OTHER;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_valid_q <= 1'b0;
    end else if (accept) begin
      tok_valid_q <= 1'b1;
    end else if (tok_ready_i) begin
      tok_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      tok_q <= tok_d;
    end
  end

  assign tok_valid_o = tok_valid_q;
  assign tok_o       = tok_q;

endmodule

// File: sv/dtiu_fifo.sv
// ----------------------------------------------------------------------------
// dtiu_fifo - token queue
// Short queue between classifier and parser.
// ----------------------------------------------------------------------------
module dtiu_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  dtiu_pkg::token_t push_tok_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output dtiu_pkg::token_t pop_tok_o
);
  import dtiu_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);

  token_t           mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [PTR_W:0]   cnt_q;
  logic             push, pop;

  assign push_ready_o = cnt_q != (PTR_W+1)'(QUEUE_DEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_tok_o    = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop) begin
        rd_q <= (rd_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_tok_i;
    end
  end

endmodule

// File: sv/dtiu_back.sv
// ----------------------------------------------------------------------------
// dtiu_back - parser and result unit
// Runs the number parser on tokens, then divides the shifted fraction
// one quotient bit per cycle and forms the result.
// ----------------------------------------------------------------------------
module dtiu_back #(
  parameter int unsigned FRACTION_DIGITS = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             tok_valid_i,
  output logic             tok_ready_o,
  input  dtiu_pkg::token_t tok_i,
  dtiu_res_if.source       res_o
);
  import dtiu_pkg::*;

  localparam int unsigned FRAC_LIMIT = 10 ** FRACTION_DIGITS;
  localparam int unsigned DIV_W      = $clog2(FRAC_LIMIT + 1);
  localparam int unsigned NUM_W      = DIV_W + int'(SHIFT_T);
  localparam int unsigned CNT_W      = $clog2(NUM_W);

  typedef enum logic [4:0] {
    PH_SKIP = 5'b00001,
    PH_INT  = 5'b00010,
    PH_FRAC = 5'b00100,
    PH_GAP  = 5'b01000,
    PH_DONE = 5'b10000
  } phase_e;

  typedef enum logic [2:0] {
    CT_PARSE = 3'b001,
    CT_DIV   = 3'b010,
    CT_SUM   = 3'b100
  } ctrl_e;

  phase_e             ph_q, ph_d;
  ctrl_e              ct_q;
  logic [63:0]        int_q, int_d, int_x10;
  logic [DIV_W-1:0]   frac_q, frac_d, frac_x10;
  logic [DIV_W-1:0]   fdiv_q, fdiv_d, fdiv_x10;
  logic [SHIFT_W-1:0] sh_q, sh_d;
  logic [DIV_W+3:0]   frac_w, fdiv_w;

  logic [63:0]        whole_q;
  logic [SHIFT_W-1:0] wsh_q;
  logic [NUM_W-1:0]   num_q;
  logic [DIV_W-1:0]   rem_q, dvs_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [DIV_W:0]     rem_sh, rem_sub;
  logic               ge;

  logic               out_valid_q;
  logic [63:0]        out_val_q;
  logic               pop, out_free;

  assign tok_ready_o = ct_q == CT_PARSE;
  assign pop         = tok_valid_i && tok_ready_o;
  assign out_free    = !out_valid_q || res_o.ready;

  assign int_x10  = (int_q << 3) + (int_q << 1) + 64'(tok_i.digit);
  assign frac_w   = (DIV_W+4)'(frac_q);
  assign fdiv_w   = (DIV_W+4)'(fdiv_q);
  assign frac_x10 = DIV_W'((frac_w << 3) + (frac_w << 1) + (DIV_W+4)'(tok_i.digit));
  assign fdiv_x10 = DIV_W'((fdiv_w << 3) + (fdiv_w << 1));

  // Parser next state for the token at the queue head
  always_comb begin
    ph_d   = ph_q;
    int_d  = int_q;
    frac_d = frac_q;
    fdiv_d = fdiv_q;
    sh_d   = sh_q;
    case (ph_q)
      PH_SKIP: begin
        if (tok_i.kind == TK_NUL) begin
          ph_d = PH_DONE;
        end else if (tok_i.kind == TK_DIGIT) begin
          int_d = 64'(tok_i.digit);
          ph_d  = PH_INT;
        end
      end
      PH_INT: begin
        if (tok_i.kind == TK_DIGIT) begin
          int_d = int_x10;
        end else if (tok_i.kind == TK_POINT) begin
          ph_d = PH_FRAC;
        end else if (tok_i.kind == TK_BLANK) begin
          ph_d = PH_GAP;
        end else begin
          sh_d = tok_i.shift;
          ph_d = PH_DONE;
        end
      end
      PH_FRAC: begin
        if (tok_i.kind == TK_DIGIT) begin
          // digits beyond the kept count are dropped
          if (fdiv_q < DIV_W'(FRAC_LIMIT)) begin
            frac_d = frac_x10;
            fdiv_d = fdiv_x10;
          end
        end else if (tok_i.kind == TK_BLANK) begin
          ph_d = PH_GAP;
        end else begin
          sh_d = tok_i.shift;
          ph_d = PH_DONE;
        end
      end
      PH_GAP: begin
        if (tok_i.kind != TK_BLANK) begin
          sh_d = tok_i.shift;
          ph_d = PH_DONE;
        end
      end
      PH_DONE: begin
        ph_d = PH_DONE;
      end
      default: begin
        ph_d = PH_SKIP;
      end
    endcase
  end

  // Restoring divide step
  assign rem_sh  = {rem_q, num_q[NUM_W-1]};
  assign ge      = rem_sh >= {1'b0, dvs_q};
  assign rem_sub = rem_sh - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q        <= PH_SKIP;
      ct_q        <= CT_PARSE;
      int_q       <= '0;
      frac_q      <= '0;
      fdiv_q      <= DIV_W'(1);
      sh_q        <= SHIFT_NONE;
      out_valid_q <= 1'b0;
    end else begin
      if (ct_q == CT_SUM && out_free) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (ct_q)
        CT_PARSE: begin
          if (pop) begin
            if (tok_i.last) begin
              ph_q   <= PH_SKIP;
              int_q  <= '0;
              frac_q <= '0;
              fdiv_q <= DIV_W'(1);
              sh_q   <= SHIFT_NONE;
              ct_q   <= CT_DIV;
            end else begin
              ph_q   <= ph_d;
              int_q  <= int_d;
              frac_q <= frac_d;
              fdiv_q <= fdiv_d;
              sh_q   <= sh_d;
            end
          end
        end
        CT_DIV: begin
          if (cnt_q == '0) begin
            ct_q <= CT_SUM;
          end
        end
        CT_SUM: begin
          if (out_free) begin
            ct_q <= CT_PARSE;
          end
        end
        default: begin
          ct_q <= CT_PARSE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (ct_q == CT_PARSE && pop && tok_i.last) begin
      whole_q <= int_d;
      wsh_q   <= sh_d;
      num_q   <= NUM_W'(frac_d) << sh_d;
      dvs_q   <= fdiv_d;
      rem_q   <= '0;
      cnt_q   <= CNT_W'(NUM_W - 1);
    end else if (ct_q == CT_DIV) begin
      rem_q <= ge ? rem_sub[DIV_W-1:0] : rem_sh[DIV_W-1:0];
      num_q <= {num_q[NUM_W-2:0], ge};
      cnt_q <= cnt_q - 1'b1;
    end
    if (ct_q == CT_SUM && out_free) begin
      out_val_q <= (whole_q << wsh_q) + 64'(num_q);
    end
  end

  assign res_o.valid     = out_valid_q;
  assign res_o.value     = out_val_q;
  assign res_o.value_int = out_val_q[31:0];

endmodule

// File: sv/decimal_text_to_integer_with_units_unit.sv
// ----------------------------------------------------------------------------
// decimal_text_to_integer_with_units_unit - decimal text to integer with units
// Parses a byte stream of decimal text with an optional fraction and a
// K/M/G/T binary suffix into a 64-bit value and its 32-bit truncation.
// ----------------------------------------------------------------------------
//   channel | dir | request payload          | accepted when
//   in_i    | in  | char_in[7:0], last       | in_i.valid && in_i.ready
//   out_o   | out | value[63:0], value_int   | out_o.valid && out_o.ready
//
// Bytes are parsed at one per cycle outside a result pass. A byte with last
// set starts a result pass through the bit-serial divider of the NUM_W-bit
// shifted fraction (NUM_W = fraction divisor width + 40, 54 at four fraction
// digits); bytes queue meanwhile and the classifier stalls on a full queue.
// Reset is asynchronous and active low; no clearing pass is needed.
// A result waiting at the output does not stop parsing of the next string.
// ----------------------------------------------------------------------------
module decimal_text_to_integer_with_units_unit #(
  parameter int unsigned FRACTION_DIGITS = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  dtiu_char_if.sink   in_i,
  dtiu_res_if.source  out_o
);
  import dtiu_pkg::*;

  // classifier -> queue
  logic   ft_valid, ft_ready;
  token_t ft_tok;
  // queue -> parser
  logic   qb_valid, qb_ready;
  token_t qb_tok;

  // Front: take each byte and tag it as digit, point, blank, end, unit or other
  dtiu_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .tok_valid_o (ft_valid),
    .tok_ready_i (ft_ready),
    .tok_o       (ft_tok)
  );

  // Queue decouples the classifier from the parser's divide pass
  dtiu_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (ft_valid),
    .push_ready_o (ft_ready),
    .push_tok_i   (ft_tok),
    .pop_valid_o  (qb_valid),
    .pop_ready_i  (qb_ready),
    .pop_tok_o    (qb_tok)
  );

  // Back: parser state machine, fraction divider, output register
  dtiu_back #(
    .FRACTION_DIGITS (FRACTION_DIGITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_valid_i (qb_valid),
    .tok_ready_o (qb_ready),
    .tok_i       (qb_tok),
    .res_o       (out_o)
  );

endmodule
